// File: rtl/core/state_vector_gate_engine_assert.svh
// Assertion macros used by the engine's controller.
`ifndef STATE_VECTOR_GATE_ENGINE_ASSERT_SVH
`define STATE_VECTOR_GATE_ENGINE_ASSERT_SVH

// Same-cycle implication on the rising edge of clk.
`define SVGE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("svge assertion failed");

// Next-cycle implication on the rising edge of clk.
`define SVGE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("svge assertion failed");

`endif

// File: rtl/core/svge_pkg.sv
// Shared constants, types and arithmetic helpers of the state vector gate engine.
package svge_pkg;

  localparam int MAX_QUBITS = 10;
  localparam int AMP_WIDTH  = 18;
  localparam int FRAC_BITS  = 16;
  localparam int FIELD_W    = 18;
  localparam int IDX_W      = MAX_QUBITS;
  localparam int VEC_DEPTH  = 1 << MAX_QUBITS;
  localparam int QN_W       = $clog2(MAX_QUBITS + 1);
  localparam int CMP_W      = (MAX_QUBITS + 1 > 11) ? MAX_QUBITS + 1 : 11;
  localparam int PROD_W     = AMP_WIDTH + 18;
  localparam int SAT_W      = AMP_WIDTH + 20;
  localparam int CFG_RESET  = 10;
  localparam logic signed [17:0] HALF_ROOT = 18'sd46341;

  typedef enum logic [2:0] {
    REQ_X,
    REQ_CNOT,
    REQ_TOFFOLI,
    REQ_HADAMARD,
    REQ_WRITE,
    REQ_READ
  } req_t;

  typedef enum logic [1:0] {
    ST_DONE,
    ST_QUBIT_RANGE,
    ST_BASIS_RANGE
  } status_t;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_GATE,
    KIND_WRITE,
    KIND_READ
  } kind_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_PAIR_RD,
    S_PAIR_MUL,
    S_WR_I,
    S_WR_J,
    S_READ_WAIT
  } state_t;

  typedef struct packed {
    logic load;
    logic clr_wr;
    logic acc_wr;
    logic acc_rd;
    logic pair_rd;
    logic mul;
    logic wr_i;
    logic wr_j;
    logic pair_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  skip;
    logic  clr_last;
    logic  pair_last;
  } sts_t;

  function automatic logic signed [AMP_WIDTH-1:0] sat_amp(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = (SAT_W'(1) <<< (AMP_WIDTH - 1)) - SAT_W'(1);
    lo = -(SAT_W'(1) <<< (AMP_WIDTH - 1));
    if (v > hi) begin
      return hi[AMP_WIDTH-1:0];
    end else if (v < lo) begin
      return lo[AMP_WIDTH-1:0];
    end
    return v[AMP_WIDTH-1:0];
  endfunction

  function automatic logic signed [AMP_WIDTH-1:0] round_sat(input logic signed [PROD_W-1:0] p);
    logic signed [SAT_W-1:0] w;
    w = (SAT_W'(p) + (SAT_W'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    return sat_amp(w);
  endfunction

endpackage

// File: rtl/core/svge_ctrl.sv
// Controller state machine of the state vector gate engine.
`include "state_vector_gate_engine_assert.svh"

module svge_ctrl
  import svge_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  output logic out_valid,
  output cmd_t cmd,
  input  sts_t sts
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.skip) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          case (sts.kind)
            KIND_WRITE: begin
              cmd.acc_wr = 1'b1;
              cmd.finish = 1'b1;
              state_nxt  = S_IDLE;
            end
            KIND_READ: begin
              cmd.acc_rd = 1'b1;
              state_nxt  = S_READ_WAIT;
            end
            KIND_GATE: begin
              state_nxt = S_PAIR_RD;
            end
            default: begin
              cmd.finish = 1'b1;
              state_nxt  = S_IDLE;
            end
          endcase
        end
      end
      S_PAIR_RD: begin
        cmd.pair_rd = 1'b1;
        state_nxt   = S_PAIR_MUL;
      end
      S_PAIR_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_WR_I;
      end
      S_WR_I: begin
        cmd.wr_i  = 1'b1;
        state_nxt = S_WR_J;
      end
      S_WR_J: begin
        cmd.wr_j = 1'b1;
        if (sts.pair_last) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          cmd.pair_step = 1'b1;
          state_nxt     = S_PAIR_RD;
        end
      end
      S_READ_WAIT: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    out_valid_nxt = cmd.finish;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  `SVGE_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `SVGE_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid)
  `SVGE_ASSERT_NOW(a_one_write, 1'b1, $onehot0({cmd.clr_wr, cmd.acc_wr, cmd.wr_i, cmd.wr_j}))
  `SVGE_ASSERT_NEXT(a_wr_i_then_j, cmd.wr_i, cmd.wr_j)

endmodule

// File: rtl/core/svge_datapath.sv
// Datapath of the state vector gate engine: amplitude memory, pair sweep, Hadamard math.
module svge_datapath
  import svge_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  cmd_t                      cmd,
  output sts_t                      sts,
  input  logic                      cfg_wr_en,
  input  logic [3:0]                cfg_wr_data,
  input  logic [2:0]                in_req_type,
  input  logic [3:0]                in_target_qubit,
  input  logic [3:0]                in_first_control,
  input  logic [3:0]                in_second_control,
  input  logic [9:0]                in_basis_index,
  input  logic signed [FIELD_W-1:0] in_write_real,
  input  logic signed [FIELD_W-1:0] in_write_imag,
  output logic signed [FIELD_W-1:0] out_read_real,
  output logic signed [FIELD_W-1:0] out_read_imag,
  output logic [1:0]                out_status
);

  logic [3:0]                cfg_r;
  logic [2:0]                req_r;
  logic [3:0]                tq_r, c1_r, c2_r;
  logic [9:0]                idx_r;
  logic signed [FIELD_W-1:0] wre_r, wim_r;
  logic [IDX_W-1:0]          clr_cnt_r;
  logic [IDX_W-1:0]          k_r;
  logic [2*AMP_WIDTH-1:0]    mem [VEC_DEPTH];
  logic [2*AMP_WIDTH-1:0]    rda_r, rdb_r;
  logic signed [PROD_W-1:0]  p0_r, p1_r, p2_r, p3_r;
  logic signed [FIELD_W-1:0] ore_r, oim_r;
  logic [1:0]                ost_r;

  logic [CMP_W-1:0]          n_ext, t_ext, c1_ext, c2_ext, idx_ext, size_ext;
  logic                      t_bad, c1_bad, c2_bad, idx_bad, noop;
  status_t                   err;
  kind_t                     kind;
  logic [QN_W-1:0]           pos_t, pos_c1, pos_c2;
  logic [IDX_W-1:0]          cm, tb, addr_i, addr_j, half_last;
  logic                      ctl_ok, is_had;
  logic                      wr_en, ra_en, rb_en;
  logic [IDX_W-1:0]          wa, ra;
  logic [2*AMP_WIDTH-1:0]    wd;
  logic signed [AMP_WIDTH-1:0] a_re, a_im, b_re, b_im, amp_one;
  logic signed [AMP_WIDTH:0] s_re, s_im, d_re, d_im;
  logic signed [SAT_W-1:0]   rd_re_w, rd_im_w;

  always_comb begin
    if (cfg_r == 4'd0) begin
      n_ext = CMP_W'(1);
    end else if (CMP_W'(cfg_r) > CMP_W'(MAX_QUBITS)) begin
      n_ext = CMP_W'(MAX_QUBITS);
    end else begin
      n_ext = CMP_W'(cfg_r);
    end
  end

  assign t_ext    = CMP_W'(tq_r);
  assign c1_ext   = CMP_W'(c1_r);
  assign c2_ext   = CMP_W'(c2_r);
  assign idx_ext  = CMP_W'(idx_r);
  assign size_ext = CMP_W'(1) << n_ext;
  assign t_bad    = t_ext >= n_ext;
  assign c1_bad   = c1_ext >= n_ext;
  assign c2_bad   = c2_ext >= n_ext;
  assign idx_bad  = idx_ext >= size_ext;

  assign pos_t  = QN_W'(n_ext - CMP_W'(1) - t_ext);
  assign pos_c1 = QN_W'(n_ext - CMP_W'(1) - c1_ext);
  assign pos_c2 = QN_W'(n_ext - CMP_W'(1) - c2_ext);

  always_comb begin
    kind   = KIND_NONE;
    err    = ST_DONE;
    noop   = 1'b0;
    cm     = '0;
    is_had = 1'b0;
    case (req_r)
      REQ_X: begin
        kind = KIND_GATE;
        if (t_bad) err = ST_QUBIT_RANGE;
      end
      REQ_CNOT: begin
        kind = KIND_GATE;
        if (t_bad || c1_bad) err = ST_QUBIT_RANGE;
        noop = (c1_r == tq_r);
        cm   = IDX_W'(1) << pos_c1;
      end
      REQ_TOFFOLI: begin
        kind = KIND_GATE;
        if (t_bad || c1_bad || c2_bad) err = ST_QUBIT_RANGE;
        noop = (c1_r == tq_r) || (c2_r == tq_r);
        cm   = (IDX_W'(1) << pos_c1) | (IDX_W'(1) << pos_c2);
      end
      REQ_HADAMARD: begin
        kind   = KIND_GATE;
        is_had = 1'b1;
        if (t_bad) err = ST_QUBIT_RANGE;
      end
      REQ_WRITE: begin
        kind = KIND_WRITE;
        if (idx_bad) err = ST_BASIS_RANGE;
      end
      REQ_READ: begin
        kind = KIND_READ;
        if (idx_bad) err = ST_BASIS_RANGE;
      end
      default: begin
        kind = KIND_NONE;
      end
    endcase
  end

  assign tb        = IDX_W'(1) << pos_t;
  assign addr_i    = (((k_r >> pos_t) << 1) << pos_t) | (k_r & (tb - IDX_W'(1)));
  assign addr_j    = addr_i | tb;
  assign ctl_ok    = (addr_i & cm) == cm;
  assign half_last = (IDX_W'(1) << QN_W'(n_ext - CMP_W'(1))) - IDX_W'(1);

  assign sts.kind      = kind;
  assign sts.skip      = (err != ST_DONE) || noop || (kind == KIND_NONE);
  assign sts.clr_last  = (clr_cnt_r == {IDX_W{1'b1}});
  assign sts.pair_last = (k_r == half_last);

  assign a_re = rda_r[2*AMP_WIDTH-1:AMP_WIDTH];
  assign a_im = rda_r[AMP_WIDTH-1:0];
  assign b_re = rdb_r[2*AMP_WIDTH-1:AMP_WIDTH];
  assign b_im = rdb_r[AMP_WIDTH-1:0];
  assign s_re = (AMP_WIDTH+1)'(a_re) + (AMP_WIDTH+1)'(b_re);
  assign s_im = (AMP_WIDTH+1)'(a_im) + (AMP_WIDTH+1)'(b_im);
  assign d_re = (AMP_WIDTH+1)'(a_re) - (AMP_WIDTH+1)'(b_re);
  assign d_im = (AMP_WIDTH+1)'(a_im) - (AMP_WIDTH+1)'(b_im);
  assign amp_one = sat_amp(SAT_W'(1) <<< FRAC_BITS);

  always_comb begin
    wr_en = cmd.clr_wr | cmd.acc_wr | cmd.wr_i | cmd.wr_j;
    wa    = addr_j;
    wd    = '0;
    if (cmd.clr_wr) begin
      wa = clr_cnt_r;
      wd = (clr_cnt_r == '0) ? {amp_one, {AMP_WIDTH{1'b0}}} : '0;
    end else if (cmd.acc_wr) begin
      wa = idx_ext[IDX_W-1:0];
      wd = {sat_amp(SAT_W'(wre_r)), sat_amp(SAT_W'(wim_r))};
    end else if (cmd.wr_i) begin
      wa = addr_i;
      if (is_had) begin
        wd = {round_sat(p0_r), round_sat(p1_r)};
      end else begin
        wd = ctl_ok ? rdb_r : rda_r;
      end
    end else begin
      if (is_had) begin
        wd = {round_sat(p2_r), round_sat(p3_r)};
      end else begin
        wd = ctl_ok ? rda_r : rdb_r;
      end
    end
    ra_en = cmd.acc_rd | cmd.pair_rd;
    rb_en = cmd.pair_rd;
    ra    = cmd.acc_rd ? idx_ext[IDX_W-1:0] : addr_i;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wa] <= wd;
    end
    if (ra_en) begin
      rda_r <= mem[ra];
    end
    if (rb_en) begin
      rdb_r <= mem[addr_j];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r     <= 4'(CFG_RESET);
      clr_cnt_r <= '0;
      k_r       <= '0;
    end else begin
      if (cfg_wr_en) begin
        cfg_r <= cfg_wr_data;
      end
      if (cmd.clr_wr) begin
        clr_cnt_r <= clr_cnt_r + IDX_W'(1);
      end
      if (cmd.load) begin
        k_r <= '0;
      end else if (cmd.pair_step) begin
        k_r <= k_r + IDX_W'(1);
      end
    end
  end

  assign rd_re_w = SAT_W'(a_re);
  assign rd_im_w = SAT_W'(a_im);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req_type;
      tq_r  <= in_target_qubit;
      c1_r  <= in_first_control;
      c2_r  <= in_second_control;
      idx_r <= in_basis_index;
      wre_r <= in_write_real;
      wim_r <= in_write_imag;
    end
    if (cmd.mul) begin
      p0_r <= PROD_W'(s_re) * PROD_W'(HALF_ROOT);
      p1_r <= PROD_W'(s_im) * PROD_W'(HALF_ROOT);
      p2_r <= PROD_W'(d_re) * PROD_W'(HALF_ROOT);
      p3_r <= PROD_W'(d_im) * PROD_W'(HALF_ROOT);
    end
    if (cmd.finish) begin
      ost_r <= err;
      if (kind == KIND_READ && err == ST_DONE) begin
        ore_r <= rd_re_w[FIELD_W-1:0];
        oim_r <= rd_im_w[FIELD_W-1:0];
      end else begin
        ore_r <= '0;
        oim_r <= '0;
      end
    end
  end

  assign out_read_real = ore_r;
  assign out_read_imag = oim_r;
  assign out_status    = ost_r;

endmodule

// File: rtl/core/state_vector_gate_engine.sv
// Top level of the state vector gate engine: controller plus datapath.
// After reset the engine clears its 1024-entry amplitude memory to |0..0>, with busy
// high throughout; start is ignored meanwhile, configuration writes are taken.
// A request is a transfer at a clock edge with start high and busy low. A gate sweeps
// every amplitude pair through the single-write-port memory, pair by pair, in order
// read both, multiply, write low entry, write high entry, for X, CNOT, Toffoli and
// Hadamard alike; a rejected or no-op gate skips the sweep, and an amplitude write
// or read does not sweep at all. The result shows on
// out_read_real, out_read_imag and out_status for exactly one cycle with out_valid
// high; the receiver cannot stall it, and a new request may be started in that cycle.
module state_vector_gate_engine
  import svge_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [2:0]                in_req_type,
  input  logic [3:0]                in_target_qubit,
  input  logic [3:0]                in_first_control,
  input  logic [3:0]                in_second_control,
  input  logic [9:0]                in_basis_index,
  input  logic signed [FIELD_W-1:0] in_write_real,
  input  logic signed [FIELD_W-1:0] in_write_imag,
  output logic                      out_valid,
  output logic signed [FIELD_W-1:0] out_read_real,
  output logic signed [FIELD_W-1:0] out_read_imag,
  output logic [1:0]                out_status,
  input  logic                      cfg_wr_en,
  input  logic [3:0]                cfg_wr_data
);

  cmd_t cmd;
  sts_t sts;

  svge_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  svge_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_req_type       (in_req_type),
    .in_target_qubit   (in_target_qubit),
    .in_first_control  (in_first_control),
    .in_second_control (in_second_control),
    .in_basis_index    (in_basis_index),
    .in_write_real     (in_write_real),
    .in_write_imag     (in_write_imag),
    .out_read_real     (out_read_real),
    .out_read_imag     (out_read_imag),
    .out_status        (out_status)
  );

endmodule

// File: verif/state_vector_gate_engine_checker.sv
// Checker for the state vector gate engine: tracks the vector, predicts and compares results.
module state_vector_gate_engine_checker
  import svge_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      busy,
  input  logic [2:0]                in_req_type,
  input  logic [3:0]                in_target_qubit,
  input  logic [3:0]                in_first_control,
  input  logic [3:0]                in_second_control,
  input  logic [9:0]                in_basis_index,
  input  logic signed [FIELD_W-1:0] in_write_real,
  input  logic signed [FIELD_W-1:0] in_write_imag,
  input  logic                      out_valid,
  input  logic signed [FIELD_W-1:0] out_read_real,
  input  logic signed [FIELD_W-1:0] out_read_imag,
  input  logic [1:0]                out_status,
  input  logic                      cfg_wr_en,
  input  logic [3:0]                cfg_wr_data,
  output int                        fail_count,
  output int                        pending_count
);

  typedef struct packed {
    logic signed [FIELD_W-1:0] re;
    logic signed [FIELD_W-1:0] im;
    status_t                   st;
  } outcome_t;

  logic signed [AMP_WIDTH-1:0] vec_re [VEC_DEPTH];
  logic signed [AMP_WIDTH-1:0] vec_im [VEC_DEPTH];
  logic [3:0] qubit_reg;
  outcome_t expected_q [$];

  function automatic logic signed [AMP_WIDTH-1:0] clip(input longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) << (AMP_WIDTH - 1)) - 1;
    lo = -(longint'(1) << (AMP_WIDTH - 1));
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[AMP_WIDTH-1:0];
  endfunction

  function automatic logic signed [AMP_WIDTH-1:0] scale_root(input longint s);
    longint p;
    longint q;
    p = s * 46341 + (longint'(1) << (FRAC_BITS - 1));
    if (p >= 0) q = p >>> FRAC_BITS;
    else q = -((-p + ((longint'(1) << FRAC_BITS) - 1)) >>> FRAC_BITS);
    return clip(q);
  endfunction

  task automatic flip_pairs(input int size, input int ctl, input int tb);
    logic signed [AMP_WIDTH-1:0] r;
    logic signed [AMP_WIDTH-1:0] m;
    for (int i = 0; i < size; i++) begin
      if ((i & ctl) == ctl && (i & tb) == 0) begin
        r = vec_re[i]; m = vec_im[i];
        vec_re[i] = vec_re[i | tb]; vec_im[i] = vec_im[i | tb];
        vec_re[i | tb] = r; vec_im[i | tb] = m;
      end
    end
  endtask

  task automatic mix_pairs(input int size, input int tb);
    longint ar, ai, br, bi;
    for (int i = 0; i < size; i++) begin
      if ((i & tb) == 0) begin
        ar = vec_re[i]; ai = vec_im[i]; br = vec_re[i | tb]; bi = vec_im[i | tb];
        vec_re[i] = scale_root(ar + br);
        vec_im[i] = scale_root(ai + bi);
        vec_re[i | tb] = scale_root(ar - br);
        vec_im[i | tb] = scale_root(ai - bi);
      end
    end
  endtask

  task automatic predict_request();
    int n, size, tb, t, c1, c2;
    logic bad;
    outcome_t o;
    n = (qubit_reg < 1) ? 1 : (qubit_reg > MAX_QUBITS) ? MAX_QUBITS : qubit_reg;
    size = 1 << n;
    t = in_target_qubit; c1 = in_first_control; c2 = in_second_control;
    o.re = '0; o.im = '0; o.st = ST_DONE;
    if (in_req_type <= REQ_HADAMARD) begin
      bad = t >= n;
      if (in_req_type == REQ_CNOT || in_req_type == REQ_TOFFOLI) bad = bad || c1 >= n;
      if (in_req_type == REQ_TOFFOLI) bad = bad || c2 >= n;
      if (bad) begin
        o.st = ST_QUBIT_RANGE;
      end else begin
        tb = 1 << (n - 1 - t);
        case (in_req_type)
          REQ_X: flip_pairs(size, 0, tb);
          REQ_CNOT: if (c1 != t) flip_pairs(size, 1 << (n - 1 - c1), tb);
          REQ_TOFFOLI: if (c1 != t && c2 != t)
            flip_pairs(size, (1 << (n - 1 - c1)) | (1 << (n - 1 - c2)), tb);
          default: mix_pairs(size, tb);
        endcase
      end
    end else if (in_req_type == REQ_WRITE || in_req_type == REQ_READ) begin
      if (in_basis_index >= size) begin
        o.st = ST_BASIS_RANGE;
      end else if (in_req_type == REQ_WRITE) begin
        vec_re[in_basis_index] = clip(longint'(in_write_real));
        vec_im[in_basis_index] = clip(longint'(in_write_imag));
      end else begin
        o.re = vec_re[in_basis_index][FIELD_W-1:0];
        o.im = vec_im[in_basis_index][FIELD_W-1:0];
      end
    end
    expected_q = {expected_q, o};
  endtask

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    outcome_t e;
    if (!rst_n) begin
      for (int i = 0; i < VEC_DEPTH; i++) begin
        vec_re[i] = '0; vec_im[i] = '0;
      end
      vec_re[0] = clip(longint'(1) << FRAC_BITS);
      qubit_reg = 4'(CFG_RESET);
      expected_q.delete();
    end else begin
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result with no request pending");
        end else begin
          e = expected_q.pop_front();
          if (out_read_real !== e.re)
            report_mismatch($sformatf("real %0d, want %0d", out_read_real, e.re));
          if (out_read_imag !== e.im)
            report_mismatch($sformatf("imag %0d, want %0d", out_read_imag, e.im));
          if (out_status !== e.st)
            report_mismatch($sformatf("status %0d, want %0d", out_status, e.st));
        end
      end
      if (start && !busy) predict_request();
      if (cfg_wr_en) qubit_reg = cfg_wr_data;
    end
    pending_count = expected_q.size();
  end

endmodule

// File: verif/state_vector_gate_engine_tb.sv
// Testbench top for the state vector gate engine: clock, reset, request stimulus and verdict.
module state_vector_gate_engine_tb;
  import svge_pkg::*;

  logic clk, rst_n, start, busy, out_valid, cfg_wr_en;
  logic [2:0] in_req_type;
  logic [3:0] in_target_qubit, in_first_control, in_second_control, cfg_wr_data;
  logic [9:0] in_basis_index;
  logic signed [FIELD_W-1:0] in_write_real, in_write_imag, out_read_real, out_read_imag;
  logic [1:0] out_status;
  int fail_count, pending_count, idle_pct;

  state_vector_gate_engine uut (.*);
  state_vector_gate_engine_checker chk (.*);

  always begin
    clk = 1'b0; #4;
    clk = 1'b1; #4;
  end

  initial begin
    #20000000;
    $display("Some tests failed");
    $finish;
  end

  task automatic send_request(input int rq, input int t, input int c1, input int c2,
                              input int idx, input int wr, input int wi);
    while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) @(negedge clk);
    start = 1'b1;
    in_req_type = 3'(rq); in_target_qubit = 4'(t); in_first_control = 4'(c1);
    in_second_control = 4'(c2); in_basis_index = 10'(idx);
    in_write_real = FIELD_W'(wr); in_write_imag = FIELD_W'(wi);
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic drain();
    while (pending_count != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_qubits(input int n);
    drain();
    cfg_wr_en = 1'b1; cfg_wr_data = 4'(n);
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  function automatic int pick_qubit(input int n);
    return ($urandom_range(9, 0) == 0) ? $urandom_range(15, 0) : $urandom_range(n - 1, 0);
  endfunction

  task automatic random_request(input int n);
    int k;
    k = $urandom_range(99, 0);
    if (k < 4) begin
      send_request($urandom_range(7, 6), $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom);
    end else if (k < 40) begin
      send_request($urandom_range(3, 0), pick_qubit(n), pick_qubit(n), pick_qubit(n),
                   $urandom, $urandom, $urandom);
    end else begin
      send_request($urandom_range(5, 4), $urandom, $urandom, $urandom,
                   ($urandom_range(7, 0) == 0) ? $urandom_range(1023, 0)
                                               : $urandom_range((1 << n) - 1, 0),
                   $urandom, $urandom);
    end
  endtask

  initial begin
    int n;
    rst_n = 1'b0; start = 1'b0; cfg_wr_en = 1'b0; cfg_wr_data = '0;
    in_req_type = REQ_X; in_target_qubit = '0; in_first_control = '0;
    in_second_control = '0; in_basis_index = '0; in_write_real = '0; in_write_imag = '0;
    idle_pct = 0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    send_request(REQ_READ, 0, 0, 0, 0, 0, 0);
    send_request(REQ_HADAMARD, 9, 0, 0, 0, 0, 0);
    send_request(REQ_READ, 0, 0, 0, 1, 0, 0);
    set_qubits(3);
    send_request(REQ_WRITE, 0, 0, 0, 7, 131071, -131072);
    send_request(REQ_WRITE, 0, 0, 0, 6, 131071, 131071);
    send_request(REQ_HADAMARD, 0, 0, 0, 0, 0, 0);
    send_request(REQ_X, 2, 0, 0, 0, 0, 0);
    send_request(REQ_CNOT, 1, 0, 0, 0, 0, 0);
    send_request(REQ_CNOT, 1, 1, 0, 0, 0, 0);
    send_request(REQ_TOFFOLI, 2, 0, 1, 0, 0, 0);
    send_request(REQ_TOFFOLI, 2, 1, 1, 0, 0, 0);
    send_request(REQ_TOFFOLI, 2, 2, 0, 0, 0, 0);
    send_request(REQ_X, 3, 0, 0, 0, 0, 0);
    send_request(REQ_TOFFOLI, 0, 1, 15, 0, 0, 0);
    send_request(REQ_WRITE, 0, 0, 0, 8, 5, 5);
    send_request(REQ_READ, 0, 0, 0, 1023, 0, 0);
    send_request(3'd6, 15, 15, 15, 1023, -1, -1);
    send_request(3'd7, 0, 0, 0, 0, 0, 0);
    for (int i = 0; i < 8; i++) send_request(REQ_READ, 0, 0, 0, i, 0, 0);

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: n = 1; 1: n = 10; 2: n = 0; 3: n = 15;
        default: n = $urandom_range(6, 2);
      endcase
      set_qubits(n);
      if (n < 1) n = 1;
      if (n > MAX_QUBITS) n = MAX_QUBITS;
      case (phase % 4)
        0: idle_pct = 0; 1: idle_pct = 55; 2: idle_pct = 15; default: idle_pct = 0;
      endcase
      for (int i = 0; i < ((n == MAX_QUBITS) ? 30 : 85); i++) begin
        if (i == 20) drain();
        random_request(n);
      end
    end
    drain();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
